/* rtl/lct_pkg.sv */
// shared types and constants for the lru cache with expiry
`default_nettype none
package lct_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int TIME_W      = 32;
    localparam int TTL_W       = 31;
    localparam int EXP_W       = 33;
    localparam int OP_W        = 3;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;
    localparam int REASON_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_GET  = 3'd0;
    localparam logic [OP_W-1:0] OP_TGET = 3'd1;
    localparam logic [OP_W-1:0] OP_PUT  = 3'd2;
    localparam logic [OP_W-1:0] OP_TPUT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

    localparam logic [REASON_W-1:0] REASON_CAP = 2'd0;
    localparam logic [REASON_W-1:0] REASON_EXP = 2'd1;
    localparam logic [REASON_W-1:0] REASON_DEL = 2'd2;

    typedef struct packed {
        logic accept;
        logic look;
        logic evict;
        logic update;
        logic load_ev;
        logic load_rsp;
    } cmd_t;

    typedef struct packed {
        logic ev_pending;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/lct_ctrl.sv */
// request sequencer for the lru cache
`default_nettype none
module lct_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  lct_pkg::sts_t     sts,
    output lct_pkg::cmd_t     cmd
);
    import lct_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_EVICT = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_EVOUT = 6'b010000,
        ST_RSP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_EVICT;
            end
            ST_EVICT: begin
                cmd.evict  = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_EVOUT;
            end
            ST_EVOUT: begin
                if (!sts.ev_pending) begin
                    state_next = ST_RSP;
                end else if (sts.out_free) begin
                    cmd.load_ev = 1'b1;
                    state_next  = ST_RSP;
                end
            end
            ST_RSP: begin
                if (sts.out_free) begin
                    cmd.load_rsp = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lct_dpath.sv */
// entry stores, match logic, recency ranks and output register
`default_nettype none
module lct_dpath #(
    parameter int ENTRIES = lct_pkg::ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  lct_pkg::cmd_t                          cmd,
    output lct_pkg::sts_t                          sts,
    input  wire logic [lct_pkg::OP_W-1:0]          s_opcode,
    input  wire logic signed [lct_pkg::KEY_W-1:0]  s_key,
    input  wire logic signed [lct_pkg::VAL_W-1:0]  s_value,
    input  wire logic [lct_pkg::TIME_W-1:0]        s_now,
    input  wire logic [lct_pkg::TTL_W-1:0]         s_ttl,
    input  wire logic                              cfg_valid,
    input  wire logic [lct_pkg::CAP_W-1:0]         cfg_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_is_eviction,
    output logic                                   m_hit,
    output logic signed [lct_pkg::VAL_W-1:0]       m_value_out,
    output logic signed [lct_pkg::KEY_W-1:0]       m_key_out,
    output logic [lct_pkg::REASON_W-1:0]           m_reason,
    output logic [lct_pkg::OCC_W-1:0]              m_occupancy,
    output logic                                   m_last
);
    import lct_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

    // request
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TTL_W-1:0]  ttl_reg;

    // stores
    logic [ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]   key_mem  [ENTRIES];
    logic [VAL_W-1:0]   val_mem  [ENTRIES];
    logic [EXP_W-1:0]   exp_mem  [ENTRIES];
    logic [IW-1:0]      rank_mem [ENTRIES];
    logic [CW-1:0]      count_reg;
    logic [CAP_W-1:0]   cap_reg;

    // lookup results
    logic [ENTRIES-1:0] match_vec_reg;
    logic               hit_reg;
    logic               hit_exp_reg;
    logic [VAL_W-1:0]   hit_val_reg;
    logic [IW-1:0]      hit_rank_reg;

    // pending event
    logic                ev_flag_reg;
    logic [KEY_W-1:0]    ev_key_reg;
    logic [VAL_W-1:0]    ev_val_reg;
    logic [REASON_W-1:0] ev_reason_reg;

    // output beat
    logic                m_valid_reg;
    logic                m_is_ev_reg;
    logic                m_hit_reg;
    logic [VAL_W-1:0]    m_val_reg;
    logic [KEY_W-1:0]    m_key_reg;
    logic [REASON_W-1:0] m_reason_reg;
    logic [OCC_W-1:0]    m_occ_reg;
    logic                m_last_reg;

    logic [ENTRIES-1:0] match_c, oldest_c, victim_c, free_c;
    logic [EXP_W-1:0]   hexp_c;
    logic [VAL_W-1:0]   hval_c, vval_c;
    logic [KEY_W-1:0]   vkey_c;
    logic [IW-1:0]      hrank_c, vrank_c, last_rank_c;
    logic               is_get_c, is_put_c, timed_c;
    logic               ev_exp_c, ev_del_c, ev_cap_c, do_ev_c, live_hit_c, free_found_c;
    logic [CMPW-1:0]    cap_eff_c, cap_ext_c;
    logic [EXP_W-1:0]   new_exp_c;
    logic               rsp_hit_c;
    logic [VAL_W-1:0]   rsp_val_c;

    assign is_get_c = (op_reg == OP_GET) || (op_reg == OP_TGET);
    assign is_put_c = (op_reg == OP_PUT) || (op_reg == OP_TPUT);
    assign timed_c  = (op_reg == OP_TGET) || (op_reg == OP_TPUT);

    always_comb begin
        cap_ext_c = CMPW'(cap_reg);
        if (cap_ext_c == '0) begin
            cap_eff_c = CMPW'(1);
        end else if (cap_ext_c > ENTRIES_C) begin
            cap_eff_c = ENTRIES_C;
        end else begin
            cap_eff_c = cap_ext_c;
        end
    end

    // parallel key compare, one-hot select of the matching entry
    always_comb begin
        hexp_c  = '0;
        hval_c  = '0;
        hrank_c = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_c[i] = valid_reg[i] && (key_mem[i] == key_reg);
            if (match_c[i]) begin
                hexp_c  = hexp_c  | exp_mem[i];
                hval_c  = hval_c  | val_mem[i];
                hrank_c = hrank_c | rank_mem[i];
            end
        end
    end

    assign ev_exp_c    = timed_c && hit_reg && hit_exp_reg;
    assign ev_del_c    = (op_reg == OP_DEL) && hit_reg;
    assign ev_cap_c    = is_put_c && !hit_reg && (CMPW'(count_reg) >= cap_eff_c);
    assign do_ev_c     = ev_exp_c || ev_del_c || ev_cap_c;
    assign live_hit_c  = hit_reg && !ev_exp_c;
    assign last_rank_c = IW'(count_reg - CW'(1));

    // lru entry holds the highest rank, which is count minus one
    always_comb begin
        vkey_c = '0;
        vval_c = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            oldest_c[i] = valid_reg[i] && (rank_mem[i] == last_rank_c);
        end
        victim_c = ev_cap_c ? oldest_c : match_vec_reg;
        vrank_c  = ev_cap_c ? last_rank_c : hit_rank_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            if (victim_c[i]) begin
                vkey_c = vkey_c | key_mem[i];
                vval_c = vval_c | val_mem[i];
            end
        end
    end

    // lowest free entry
    always_comb begin
        free_c       = '0;
        free_found_c = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!valid_reg[i] && !free_found_c) begin
                free_c[i]    = 1'b1;
                free_found_c = 1'b1;
            end
        end
    end

    assign new_exp_c = ((op_reg == OP_TPUT) && (ttl_reg != '0))
                     ? ({1'b0, now_reg} + {2'b00, ttl_reg}) : '0;

    always_comb begin
        rsp_hit_c = 1'b0;
        rsp_val_c = '0;
        if (is_get_c) begin
            rsp_hit_c = live_hit_c;
            rsp_val_c = live_hit_c ? hit_val_reg : '1;
        end else if (is_put_c) begin
            rsp_hit_c = 1'b1;
            rsp_val_c = val_reg;
        end else if (op_reg == OP_DEL) begin
            rsp_hit_c = hit_reg;
            rsp_val_c = hit_reg ? hit_val_reg : '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            ev_flag_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (cmd.accept) begin
                ev_flag_reg <= 1'b0;
            end
            if (cmd.evict && do_ev_c) begin
                ev_flag_reg <= 1'b1;
                valid_reg   <= valid_reg & ~victim_c;
                if (count_reg != '0) begin
                    count_reg <= count_reg - CW'(1);
                end
            end
            if (cmd.update && is_put_c && !live_hit_c && free_found_c) begin
                valid_reg <= valid_reg | free_c;
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.load_ev || cmd.load_rsp) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= s_opcode;
            key_reg <= s_key;
            val_reg <= s_value;
            now_reg <= s_now;
            ttl_reg <= s_ttl;
        end
        if (cmd.look) begin
            match_vec_reg <= match_c;
            hit_reg       <= |match_c;
            hit_val_reg   <= hval_c;
            hit_rank_reg  <= hrank_c;
            hit_exp_reg   <= (hexp_c != '0) && ({1'b0, now_reg} >= hexp_c);
        end
        if (cmd.evict && do_ev_c) begin
            ev_key_reg    <= vkey_c;
            ev_val_reg    <= vval_c;
            ev_reason_reg <= ev_cap_c ? REASON_CAP : (ev_exp_c ? REASON_EXP : REASON_DEL);
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_reg[i] && (rank_mem[i] > vrank_c)) begin
                    rank_mem[i] <= rank_mem[i] - IW'(1);
                end
            end
        end
        if (cmd.update) begin
            if ((is_get_c || is_put_c) && live_hit_c) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (match_vec_reg[i]) begin
                        rank_mem[i] <= '0;
                        if (is_put_c) begin
                            val_mem[i] <= val_reg;
                            if (timed_c) begin
                                exp_mem[i] <= new_exp_c;
                            end
                        end
                    end else if (valid_reg[i] && (rank_mem[i] < hit_rank_reg)) begin
                        rank_mem[i] <= rank_mem[i] + IW'(1);
                    end
                end
            end else if (is_put_c && free_found_c) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (free_c[i]) begin
                        key_mem[i]  <= key_reg;
                        val_mem[i]  <= val_reg;
                        exp_mem[i]  <= new_exp_c;
                        rank_mem[i] <= '0;
                    end else if (valid_reg[i]) begin
                        rank_mem[i] <= rank_mem[i] + IW'(1);
                    end
                end
            end
        end
        if (cmd.load_ev) begin
            m_is_ev_reg  <= 1'b1;
            m_hit_reg    <= 1'b0;
            m_val_reg    <= ev_val_reg;
            m_key_reg    <= ev_key_reg;
            m_reason_reg <= ev_reason_reg;
            m_occ_reg    <= OCC_W'(count_reg);
            m_last_reg   <= 1'b0;
        end else if (cmd.load_rsp) begin
            m_is_ev_reg  <= 1'b0;
            m_hit_reg    <= rsp_hit_c;
            m_val_reg    <= rsp_val_c;
            m_key_reg    <= key_reg;
            m_reason_reg <= REASON_CAP;
            m_occ_reg    <= OCC_W'(count_reg);
            m_last_reg   <= 1'b1;
        end
    end

    assign sts.ev_pending = ev_flag_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_is_eviction = m_is_ev_reg;
    assign m_hit         = m_hit_reg;
    assign m_value_out   = m_val_reg;
    assign m_key_out     = m_key_reg;
    assign m_reason      = m_reason_reg;
    assign m_occupancy   = m_occ_reg;
    assign m_last        = m_last_reg;

endmodule
`default_nettype wire

/* rtl/lru_cache_with_ttl_top.sv */
// top level of the lru key/value cache with expiry times
// event beat: loaded in the event-out state, after lookup, eviction and update
// response beat: loaded in the response state; one request at a time, the
//   sequencer walking lookup, eviction, update and two output slots
// reset: synchronous active-low aresetn empties the cache and sets capacity to 16
// entry payload stores are not cleared, only their valid bits
`default_nettype none
module lru_cache_with_ttl_top #(
    parameter int ENTRIES = lct_pkg::ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [lct_pkg::OP_W-1:0]          s_opcode,
    input  wire logic signed [lct_pkg::KEY_W-1:0]  s_key,
    input  wire logic signed [lct_pkg::VAL_W-1:0]  s_value,
    input  wire logic [lct_pkg::TIME_W-1:0]        s_now,
    input  wire logic [lct_pkg::TTL_W-1:0]         s_ttl,
    // capacity register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lct_pkg::CAP_W-1:0]         cfg_data,
    // result channel: an eviction event, if any, then the response
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_is_eviction,
    output logic                                   m_hit,
    output logic signed [lct_pkg::VAL_W-1:0]       m_value_out,
    output logic signed [lct_pkg::KEY_W-1:0]       m_key_out,
    output logic [lct_pkg::REASON_W-1:0]           m_reason,
    output logic [lct_pkg::OCC_W-1:0]              m_occupancy,
    output logic                                   m_last
);
    import lct_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // capacity writes are always taken in one beat
    assign cfg_ready = 1'b1;

    // sequencer: idle, lookup, evict, update, event out, response out
    lct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stores, key match, rank bookkeeping and the output register
    lct_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_opcode      (s_opcode),
        .s_key         (s_key),
        .s_value       (s_value),
        .s_now         (s_now),
        .s_ttl         (s_ttl),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_eviction (m_is_eviction),
        .m_hit         (m_hit),
        .m_value_out   (m_value_out),
        .m_key_out     (m_key_out),
        .m_reason      (m_reason),
        .m_occupancy   (m_occupancy),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

/* rtl/lct_checker.sv */
// port-level checks for the lru cache, bound to the top level
`default_nettype none
module lct_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic                              m_is_eviction,
    input wire logic                              m_hit,
    input wire logic signed [lct_pkg::VAL_W-1:0]  m_value_out,
    input wire logic signed [lct_pkg::KEY_W-1:0]  m_key_out,
    input wire logic [lct_pkg::REASON_W-1:0]      m_reason,
    input wire logic                              m_last
);
    import lct_pkg::*;

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out) && $stable(m_key_out))
        else $error("result beat changed while stalled");

    // events are never the final beat and carry no hit
    a_ev_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_eviction |-> !m_last && !m_hit)
        else $error("malformed eviction beat");

    // responses close the request with a zero reason
    a_rsp_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_eviction |-> m_last && (m_reason == REASON_CAP))
        else $error("malformed response beat");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

endmodule

bind lru_cache_with_ttl_top lct_checker u_lct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_is_eviction (m_is_eviction),
    .m_hit         (m_hit),
    .m_value_out   (m_value_out),
    .m_key_out     (m_key_out),
    .m_reason      (m_reason),
    .m_last        (m_last)
);
`default_nettype wire
